FILE: rtl/u16550_pkg.sv
// ----------------------------------------------------------------------------
// u16550_pkg
// Types, constants and helper functions shared by the UART register block.
// ----------------------------------------------------------------------------
package u16550_pkg;

  localparam int unsigned TX_DEPTH = 64;
  localparam int unsigned RX_DEPTH = 64;
  localparam logic [15:0] DEFAULT_DIVISOR = 16'd1;

  localparam int unsigned TX_PTR_W = $clog2(TX_DEPTH);
  localparam int unsigned RX_PTR_W = $clog2(RX_DEPTH);
  localparam int unsigned TX_CNT_W = $clog2(TX_DEPTH + 1);
  localparam int unsigned RX_CNT_W = $clog2(RX_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_REG_WRITE  = 2'd0,
    CMD_REG_READ   = 2'd1,
    CMD_HOST_RX    = 2'd2,
    CMD_HOST_DRAIN = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_RBR_THR = 3'd0;
  localparam logic [2:0] REG_IER     = 3'd1;
  localparam logic [2:0] REG_IIR_FCR = 3'd2;
  localparam logic [2:0] REG_LCR     = 3'd3;
  localparam logic [2:0] REG_MCR     = 3'd4;
  localparam logic [2:0] REG_LSR     = 3'd5;
  localparam logic [2:0] REG_MSR     = 3'd6;
  localparam logic [2:0] REG_SCR     = 3'd7;

  localparam logic [7:0] IIR_NONE = 8'h01;
  localparam logic [7:0] IIR_TXE  = 8'h02;
  localparam logic [7:0] IIR_RXD  = 8'h0C;
  localparam logic [7:0] IIR_FIFO_ON = 8'hC0;
  localparam logic [7:0] FCR_KEEP_MASK = 8'hC9;
  localparam logic [7:0] LSR_THRE_TEMT = 8'h60;
  localparam logic [7:0] LSR_DR = 8'h01;
  localparam logic [7:0] RBR_EMPTY = 8'hFF;

  function automatic logic [TX_PTR_W-1:0] tx_ptr_inc(input logic [TX_PTR_W-1:0] p);
    return (p == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [RX_PTR_W-1:0] rx_ptr_inc(input logic [RX_PTR_W-1:0] p);
    return (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

FILE: rtl/uart_16550_register_model.sv
// ----------------------------------------------------------------------------
// uart_16550_register_model
// 16550-style register face with transmit and receive FIFOs.
// ----------------------------------------------------------------------------
// Each input transfer carries one command in s_tuser: a register write, a
// register read, a character from the host into the receive FIFO, or a drain
// of one character from the transmit FIFO. Every command gives exactly one
// output transfer with the read data, the drained character, its valid flag
// and the interrupt pin level after the command.
// An accepted input transfer first updates the registers, pointers and FIFO
// memories and takes the synchronous memory read into the middle stage; the
// output register is then loaded from the middle stage. A new input transfer
// is taken in every cycle while the output side keeps up.
// When the receiver stalls, the output register holds its transfer and the
// middle stage holds one more; s_tready then falls until m_tready returns.
// Reset empties both FIFOs through their counts and pointers, returns the
// registers to their reset values and clears the polarity setting; no
// clearing pass over the memories is needed.
// ----------------------------------------------------------------------------
module uart_16550_register_model
  import u16550_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // reg_offset[2:0], write_data[10:3], rx_char[18:11], zero
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // read_data[7:0], tx_char[15:8], irq_level[16], zero
  output logic        m_tuser    // tx_valid[0]
);

  logic       irq_active_low;
  cmd_t       cmd;
  logic [2:0] reg_offset;
  logic [7:0] write_data;
  logic [7:0] rx_char;

  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_q;
  logic [7:0] rx_q;

  logic [TX_PTR_W-1:0] tx_rd_ptr, tx_rd_ptr_next, tx_wr_ptr, tx_wr_ptr_next;
  logic [TX_CNT_W-1:0] tx_count, tx_count_next;
  logic [RX_PTR_W-1:0] rx_rd_ptr, rx_rd_ptr_next, rx_wr_ptr, rx_wr_ptr_next;
  logic [RX_CNT_W-1:0] rx_count, rx_count_next;

  logic [3:0] int_enable, int_enable_next;
  logic [7:0] line_control, line_control_next;
  logic [7:0] fifo_control, fifo_control_next;
  logic [7:0] scratch, scratch_next;
  logic [7:0] divisor_low, divisor_low_next;
  logic [7:0] divisor_high, divisor_high_next;
  logic       tx_empty_pending, tx_empty_pending_next;

  logic       accept;
  logic       advance;
  logic       tx_push, tx_pop, rx_push, rx_pop, rx_clear;
  logic       dlab;
  logic [7:0] iir_code;
  logic [7:0] rd_value;
  logic       irq_pending_next;

  logic       a_valid;
  logic       a_rx_pop;
  logic       a_tx_valid;
  logic [7:0] a_read_data;
  logic       a_irq;

  logic       out_valid;
  logic [7:0] out_read_data;
  logic [7:0] out_tx_char;
  logic       out_tx_valid;
  logic       out_irq;

  assign cmd        = cmd_t'(s_tuser);
  assign reg_offset = s_tdata[2:0];
  assign write_data = s_tdata[10:3];
  assign rx_char    = s_tdata[18:11];

  assign advance  = !out_valid || m_tready;
  assign s_tready = !rst && (!a_valid || advance);
  assign accept   = s_tvalid && s_tready;
  assign dlab     = line_control[7];

  always_comb begin
    if (rx_count != '0 && int_enable[0]) begin
      iir_code = IIR_RXD;
    end else if (tx_empty_pending && int_enable[1]) begin
      iir_code = IIR_TXE;
    end else begin
      iir_code = IIR_NONE;
    end
  end

  always_comb begin
    tx_push               = 1'b0;
    tx_pop                = 1'b0;
    rx_push               = 1'b0;
    rx_pop                = 1'b0;
    rx_clear              = 1'b0;
    rd_value              = 8'h00;
    int_enable_next       = int_enable;
    line_control_next     = line_control;
    fifo_control_next     = fifo_control;
    scratch_next          = scratch;
    divisor_low_next      = divisor_low;
    divisor_high_next     = divisor_high;
    tx_empty_pending_next = tx_empty_pending;
    if (accept) begin
      case (cmd)
        CMD_REG_WRITE: begin
          if (dlab && reg_offset == REG_RBR_THR) begin
            divisor_low_next = write_data;
          end else if (dlab && reg_offset == REG_IER) begin
            divisor_high_next = write_data;
          end else begin
            case (reg_offset)
              REG_RBR_THR: begin
                tx_push               = 1'b1;
                tx_empty_pending_next = 1'b1;
              end
              REG_IER: int_enable_next = write_data[3:0];
              REG_IIR_FCR: begin
                if (!write_data[0]) begin
                  fifo_control_next = 8'h00;
                end else begin
                  rx_clear          = write_data[1];
                  fifo_control_next = write_data & FCR_KEEP_MASK;
                end
              end
              REG_LCR: line_control_next = write_data;
              REG_SCR: scratch_next = write_data;
              default: ;
            endcase
          end
        end
        CMD_REG_READ: begin
          if (dlab && reg_offset == REG_RBR_THR) begin
            rd_value = divisor_low;
          end else if (dlab && reg_offset == REG_IER) begin
            rd_value = divisor_high;
          end else begin
            case (reg_offset)
              REG_RBR_THR: begin
                rx_pop   = (rx_count != '0);
                rd_value = RBR_EMPTY;
              end
              REG_IER: rd_value = {4'h0, int_enable};
              REG_IIR_FCR: begin
                if (iir_code == IIR_TXE) begin
                  tx_empty_pending_next = 1'b0;
                end
                rd_value = (fifo_control[0] ? IIR_FIFO_ON : 8'h00) | iir_code;
              end
              REG_LCR: rd_value = line_control;
              REG_LSR: rd_value = LSR_THRE_TEMT | ((rx_count != '0) ? LSR_DR : 8'h00);
              REG_SCR: rd_value = scratch;
              default: rd_value = 8'h00;
            endcase
          end
        end
        CMD_HOST_RX:    rx_push = 1'b1;
        CMD_HOST_DRAIN: tx_pop  = (tx_count != '0);
        default: ;
      endcase
    end
  end

  always_comb begin
    tx_rd_ptr_next = tx_rd_ptr;
    tx_wr_ptr_next = tx_wr_ptr;
    tx_count_next  = tx_count;
    if (tx_push) begin
      tx_wr_ptr_next = tx_ptr_inc(tx_wr_ptr);
      if (tx_count == TX_CNT_W'(TX_DEPTH)) begin
        tx_rd_ptr_next = tx_ptr_inc(tx_rd_ptr);
      end else begin
        tx_count_next = tx_count + 1'b1;
      end
    end else if (tx_pop) begin
      tx_rd_ptr_next = tx_ptr_inc(tx_rd_ptr);
      tx_count_next  = tx_count - 1'b1;
    end
  end

  always_comb begin
    rx_rd_ptr_next = rx_rd_ptr;
    rx_wr_ptr_next = rx_wr_ptr;
    rx_count_next  = rx_count;
    if (rx_clear) begin
      rx_rd_ptr_next = '0;
      rx_wr_ptr_next = '0;
      rx_count_next  = '0;
    end else if (rx_push) begin
      rx_wr_ptr_next = rx_ptr_inc(rx_wr_ptr);
      if (rx_count == RX_CNT_W'(RX_DEPTH)) begin
        rx_rd_ptr_next = rx_ptr_inc(rx_rd_ptr);
      end else begin
        rx_count_next = rx_count + 1'b1;
      end
    end else if (rx_pop) begin
      rx_rd_ptr_next = rx_ptr_inc(rx_rd_ptr);
      rx_count_next  = rx_count - 1'b1;
    end
  end

  assign irq_pending_next = (rx_count_next != '0 && int_enable_next[0]) ||
                            (tx_empty_pending_next && int_enable_next[1]);

  always_ff @(posedge clk) begin
    if (tx_push) begin
      tx_mem[tx_wr_ptr] <= write_data;
    end
    if (tx_pop) begin
      tx_q <= tx_mem[tx_rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rx_push) begin
      rx_mem[rx_wr_ptr] <= rx_char;
    end
    if (rx_pop) begin
      rx_q <= rx_mem[rx_rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_active_low   <= 1'b0;
      tx_rd_ptr        <= '0;
      tx_wr_ptr        <= '0;
      tx_count         <= '0;
      rx_rd_ptr        <= '0;
      rx_wr_ptr        <= '0;
      rx_count         <= '0;
      int_enable       <= '0;
      line_control     <= '0;
      fifo_control     <= '0;
      scratch          <= '0;
      divisor_low      <= DEFAULT_DIVISOR[7:0];
      divisor_high     <= DEFAULT_DIVISOR[15:8];
      tx_empty_pending <= 1'b0;
      a_valid          <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        irq_active_low <= cfg_wdata;
      end
      tx_rd_ptr        <= tx_rd_ptr_next;
      tx_wr_ptr        <= tx_wr_ptr_next;
      tx_count         <= tx_count_next;
      rx_rd_ptr        <= rx_rd_ptr_next;
      rx_wr_ptr        <= rx_wr_ptr_next;
      rx_count         <= rx_count_next;
      int_enable       <= int_enable_next;
      line_control     <= line_control_next;
      fifo_control     <= fifo_control_next;
      scratch          <= scratch_next;
      divisor_low      <= divisor_low_next;
      divisor_high     <= divisor_high_next;
      tx_empty_pending <= tx_empty_pending_next;
      if (accept) begin
        a_valid <= 1'b1;
      end else if (advance) begin
        a_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_rx_pop    <= rx_pop;
      a_tx_valid  <= tx_pop;
      a_read_data <= rd_value;
      a_irq       <= irq_pending_next ^ irq_active_low;
    end
    if (a_valid && advance) begin
      out_read_data <= a_rx_pop ? rx_q : a_read_data;
      out_tx_char   <= a_tx_valid ? tx_q : 8'h00;
      out_tx_valid  <= a_tx_valid;
      out_irq       <= a_irq;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'h00, out_irq, out_tx_char, out_read_data};
  assign m_tuser  = out_tx_valid;

endmodule

FILE: rtl/u16550_checker.sv
// ----------------------------------------------------------------------------
// u16550_checker
// Port-level checks on the UART register block, bound to the top level.
// ----------------------------------------------------------------------------
module u16550_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser
);

  // A stalled output transfer keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output payload changed while stalled");

  // An output without tx_valid, such as a drain that found nothing, reports a zero character.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[15:8] == 8'h00)
    else $error("character reported without tx_valid");

  // Nothing is offered straight after reset.
  assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid straight after reset");

  // A fresh output traces back to an accepted input transfer through the middle stage and the output register.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("output appeared without a matching input transfer");

endmodule

bind uart_16550_register_model u16550_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
